// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers. The assertions drop out of synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check that the consequent holds in the same cycle as the antecedent
`define ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that the consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ASSERT_SAME(lbl, ante, cons, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== src/i2cmbe_pkg.sv =====
// ----------------------------------------------------------------------------
// I2C master bit engine package
// Opcodes, transfer payload types and the phase count table.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cmbe_pkg;

  // Command opcodes
  localparam logic [2:0] OP_START = 3'd0;
  localparam logic [2:0] OP_STOP  = 3'd1;
  localparam logic [2:0] OP_ACK   = 3'd2;
  localparam logic [2:0] OP_NACK  = 3'd3;
  localparam logic [2:0] OP_WAIT  = 3'd4;
  localparam logic [2:0] OP_SEND  = 3'd5;
  localparam logic [2:0] OP_RECV  = 3'd6;
  localparam logic [2:0] OP_NONE  = 3'd7;

  localparam logic [7:0] PHASE_TICKS_RESET = 8'd50;

  // One tick offered to the engine
  typedef struct packed {
    logic       cmd_valid;
    logic [2:0] opcode;
    logic [7:0] tx_byte;
    logic       sda_in;
  } cmd_item_t;

  // Line drive and status after one tick
  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       ready_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_ok;
    logic       start_ok;
  } res_item_t;

  // Number of phases in each command's sequence
  function automatic logic [4:0] phase_total(input logic [2:0] op);
    logic [4:0] n;
    case (op)
      OP_START: n = 5'd3;
      OP_STOP:  n = 5'd4;
      OP_ACK:   n = 5'd4;
      OP_NACK:  n = 5'd4;
      OP_WAIT:  n = 5'd3;
      OP_SEND:  n = 5'd24;
      OP_RECV:  n = 5'd16;
      default:  n = 5'd1;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

// ===== src/i2cmbe_if.sv =====
// ----------------------------------------------------------------------------
// I2C master bit engine channels
// Valid/ready channels for the tick input and the result output.
// ----------------------------------------------------------------------------
`default_nettype none

interface i2cmbe_cmd_if;
  import i2cmbe_pkg::*;

  logic      valid;
  logic      ready;
  cmd_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface i2cmbe_res_if;
  import i2cmbe_pkg::*;

  logic      valid;
  logic      ready;
  res_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== src/i2c_master_bit_engine_unit.sv =====
// ----------------------------------------------------------------------------
// I2C master bit engine
// Sequences SCL and SDA for start, stop, ack, nack, wait-ack and byte transfers.
// ----------------------------------------------------------------------------
// Usage:
//   cmd : one transfer per time tick, carrying an optional command and the
//         sampled SDA level. A command is taken only while the engine is idle.
//   res : one transfer per accepted tick, carrying the SCL/SDA drive levels,
//         ready/done flags, the last received byte and the ack/start status.
//   cfg_we/cfg_wdata : write phase_ticks (ticks each phase is held, 0 acts
//         as 1); write it while no tick is in flight. A new value applies at
//         once, so a running phase ends as soon as its count reaches it.
// Result: the result of a tick is registered and presented in the cycle after its transfer.
// Throughput: one tick per cycle; the next-state logic and the result
//   register form a single pass, so a tick is taken in every cycle in which
//   the result register is empty or being drained.
// Reset: engine idle, both lines released, status and received byte cleared,
//   phase_ticks back to 50.
// Stall: while res is not ready the held result waits and cmd.ready drops,
//   so no tick is lost and the engine state does not advance.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module i2c_master_bit_engine_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [7:0]  cfg_wdata,
  i2cmbe_cmd_if.sink       cmd,
  i2cmbe_res_if.source     res
);
  import i2cmbe_pkg::*;

  // Engine state
  logic [7:0] phase_ticks;
  logic [4:0] seq_step;
  logic [7:0] tick_count;
  logic [7:0] shift_reg;
  logic [1:0] sub_phase;
  logic [2:0] active_cmd;
  logic       scl_level;
  logic       sda_level;
  logic [1:0] status_flags;
  logic [7:0] rx_hold;

  logic [4:0] seq_step_next;
  logic [7:0] tick_count_next;
  logic [7:0] shift_reg_next;
  logic [1:0] sub_phase_next;
  logic [2:0] active_cmd_next;
  logic       scl_level_next;
  logic       sda_level_next;
  logic [1:0] status_flags_next;
  logic [7:0] rx_hold_next;
  logic       done_next;

  // Result register
  logic      res_valid;
  res_item_t res_data;

  logic       accept;
  logic [7:0] eff_ticks;
  logic [7:0] count_inc;
  logic [4:0] cur_k;
  logic       last_phase;
  logic       fail;
  logic       enter_en;
  logic [2:0] enter_cmd;
  logic [4:0] enter_k;
  logic [1:0] enter_sub;
  logic [1:0] sub_wrap;

  assign cmd.ready = !res_valid || res.ready;
  assign accept    = cmd.valid && cmd.ready;
  assign res.valid = res_valid;
  assign res.data  = res_data;

  assign eff_ticks  = (phase_ticks == 8'd0) ? 8'd1 : phase_ticks;
  assign count_inc  = tick_count + 8'd1;
  assign cur_k      = seq_step - 5'd1;
  assign last_phase = seq_step >= phase_total(active_cmd);
  assign sub_wrap   = (active_cmd == OP_SEND) ? 2'd2 : 2'd1;

  // Work out the state after this tick
  always_comb begin
    seq_step_next     = seq_step;
    tick_count_next   = tick_count;
    shift_reg_next    = shift_reg;
    sub_phase_next    = sub_phase;
    active_cmd_next   = active_cmd;
    scl_level_next    = scl_level;
    sda_level_next    = sda_level;
    status_flags_next = status_flags;
    rx_hold_next      = rx_hold;
    done_next         = 1'b0;
    fail              = 1'b0;
    enter_en          = 1'b0;
    enter_cmd         = active_cmd;
    enter_k           = 5'd0;
    enter_sub         = 2'd0;

    if (seq_step == 5'd0) begin
      // Idle: take a command and open its first phase
      if (cmd.data.cmd_valid && cmd.data.opcode != OP_NONE) begin
        active_cmd_next = cmd.data.opcode;
        tick_count_next = 8'd0;
        shift_reg_next  = (cmd.data.opcode == OP_SEND) ? cmd.data.tx_byte : 8'd0;
        seq_step_next   = 5'd1;
        sub_phase_next  = 2'd0;
        enter_en        = 1'b1;
        enter_cmd       = cmd.data.opcode;
      end
    end else if (count_inc >= eff_ticks) begin
      // Phase end: sample, then advance or finish
      case (active_cmd)
        OP_START: begin
          if ((cur_k == 5'd0 && !cmd.data.sda_in) || (cur_k == 5'd1 && cmd.data.sda_in)) begin
            fail                 = 1'b1;
            status_flags_next[1] = 1'b0;
          end
          if (cur_k == 5'd2) begin
            status_flags_next[1] = 1'b1;
          end
        end
        OP_WAIT: begin
          if (last_phase) begin
            status_flags_next[0] = !cmd.data.sda_in;
            scl_level_next       = 1'b0;
          end
        end
        OP_SEND: begin
          if (last_phase) begin
            scl_level_next = 1'b0;
          end
        end
        OP_RECV: begin
          if (sub_phase[0]) begin
            shift_reg_next = {shift_reg[6:0], cmd.data.sda_in};
          end
          if (last_phase) begin
            scl_level_next = 1'b0;
            rx_hold_next   = shift_reg_next;
          end
        end
        default: begin
        end
      endcase
      tick_count_next = 8'd0;
      if (fail || last_phase) begin
        seq_step_next = 5'd0;
        done_next     = 1'b1;
      end else begin
        seq_step_next  = seq_step + 5'd1;
        sub_phase_next = (sub_phase == sub_wrap) ? 2'd0 : sub_phase + 2'd1;
        enter_en       = 1'b1;
        enter_k        = seq_step;
        enter_sub      = sub_phase_next;
      end
    end else begin
      tick_count_next = count_inc;
    end

    // Apply the line levels of the phase being entered
    if (enter_en) begin
      case (enter_cmd)
        OP_START: begin
          if (enter_k == 5'd0) begin
            sda_level_next = 1'b1;
            scl_level_next = 1'b1;
          end else begin
            sda_level_next = 1'b0;
          end
        end
        OP_STOP: begin
          case (enter_k)
            5'd0:    scl_level_next = 1'b0;
            5'd1:    sda_level_next = 1'b0;
            5'd2:    scl_level_next = 1'b1;
            default: sda_level_next = 1'b1;
          endcase
        end
        OP_ACK, OP_NACK: begin
          case (enter_k)
            5'd0:    scl_level_next = 1'b0;
            5'd1:    sda_level_next = (enter_cmd == OP_NACK);
            5'd2:    scl_level_next = 1'b1;
            default: scl_level_next = 1'b0;
          endcase
        end
        OP_WAIT: begin
          case (enter_k)
            5'd0:    scl_level_next = 1'b0;
            5'd1:    sda_level_next = 1'b1;
            default: scl_level_next = 1'b1;
          endcase
        end
        OP_SEND: begin
          case (enter_sub)
            2'd0: scl_level_next = 1'b0;
            2'd1: begin
              sda_level_next = shift_reg_next[7];
              shift_reg_next = {shift_reg_next[6:0], 1'b0};
            end
            default: scl_level_next = 1'b1;
          endcase
        end
        OP_RECV: begin
          if (!enter_sub[0]) begin
            if (enter_k == 5'd0) begin
              sda_level_next = 1'b1;
            end
            scl_level_next = 1'b0;
          end else begin
            scl_level_next = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Hold the phase length register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_ticks <= PHASE_TICKS_RESET;
    end else if (cfg_we) begin
      phase_ticks <= cfg_wdata;
    end
  end

  // Advance the engine on each accepted tick
  always_ff @(posedge clk) begin
    if (rst) begin
      seq_step     <= 5'd0;
      tick_count   <= 8'd0;
      shift_reg    <= 8'd0;
      sub_phase    <= 2'd0;
      active_cmd   <= OP_START;
      scl_level    <= 1'b1;
      sda_level    <= 1'b1;
      status_flags <= 2'd0;
      rx_hold      <= 8'd0;
    end else if (accept) begin
      seq_step     <= seq_step_next;
      tick_count   <= tick_count_next;
      shift_reg    <= shift_reg_next;
      sub_phase    <= sub_phase_next;
      active_cmd   <= active_cmd_next;
      scl_level    <= scl_level_next;
      sda_level    <= sda_level_next;
      status_flags <= status_flags_next;
      rx_hold      <= rx_hold_next;
    end
  end

  // Load the result register; drop it once transferred
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_data.scl_out   <= scl_level_next;
      res_data.sda_out   <= sda_level_next;
      res_data.ready_res <= (seq_step_next == 5'd0);
      res_data.done_res  <= done_next;
      res_data.rx_byte   <= rx_hold_next;
      res_data.ack_ok    <= status_flags_next[0];
      res_data.start_ok  <= status_flags_next[1];
    end
  end

  // Checks
  `ASSERT_SAME(a_done_means_idle, res_valid && res_data.done_res, res_data.ready_res, "done without idle")
  `ASSERT_SAME(a_idle_count_clear, seq_step == 5'd0, tick_count == 8'd0, "idle with running count")
  `ASSERT_SAME(a_step_in_range, seq_step != 5'd0, seq_step <= phase_total(active_cmd), "phase step out of range")
  `ASSERT_NEXT(a_hold_when_stalled, !accept, $stable(seq_step) && $stable(tick_count), "state moved without a tick")

endmodule

`default_nettype wire

// ===== sim/i2c_master_bit_engine_unit_tb.sv =====
// ----------------------------------------------------------------------------
// I2C master bit engine testbench
// Drives time ticks with optional commands and a sampled SDA level into the
// engine, and mirrors its phase sequencing in a line model. Every result
// transfer is compared field by field with the oldest forecast. A directed
// table comes first, then three random phases with different stall patterns.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_master_bit_engine_unit_tb;
  import i2cmbe_pkg::*;

  // How the SDA level offered with a tick is chosen
  typedef enum logic [1:0] {SDA_FOLLOW, SDA_LOW, SDA_HIGH, SDA_RAND} sda_mode_e;

  // One line of the directed table: a command run until the engine is idle
  typedef struct {
    int         cfg_before;
    bit         valid;
    logic [2:0] op;
    logic [7:0] tx;
    sda_mode_e  mode;
    bit         noise;
    int         mid_tick;
    int         mid_cfg;
    bit         typed;
    res_item_t  want;
  } step_row_t;

  localparam int NO_CFG = -1;
  localparam int MAX_PRINTED = 40;

  // Phase count of each opcode, five bits per entry, opcode 0 lowest
  localparam logic [39:0] PHASE_LEN = {5'd1, 5'd16, 5'd24, 5'd3, 5'd4, 5'd4, 5'd4, 5'd3};

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_we;
  logic [7:0] cfg_wdata;

  i2cmbe_cmd_if cmd_ch ();
  i2cmbe_res_if res_ch ();

  i2c_master_bit_engine_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd_ch),
    .res       (res_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Line model of the engine
  logic [7:0] m_phase_ticks;
  logic [4:0] m_step;
  logic [7:0] m_count;
  logic [7:0] m_shift;
  logic [2:0] m_cmd;
  logic       m_scl;
  logic       m_sda;
  logic [1:0] m_flags;
  logic [7:0] m_rx;

  res_item_t  bus_state_q[$];
  step_row_t  plan[$];
  res_item_t  want_res;
  int         fail_count = 0;
  int         res_count = 0;
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;

  // Apply the line levels of phase k of the active command
  function automatic void drive_phase(input int k);
    case (m_cmd)
      OP_START: begin
        if (k == 0) begin
          m_sda = 1'b1;
          m_scl = 1'b1;
        end else begin
          m_sda = 1'b0;
        end
      end
      OP_STOP: begin
        if (k == 0) m_scl = 1'b0;
        else if (k == 1) m_sda = 1'b0;
        else if (k == 2) m_scl = 1'b1;
        else m_sda = 1'b1;
      end
      OP_ACK, OP_NACK: begin
        if (k == 0) m_scl = 1'b0;
        else if (k == 1) m_sda = (m_cmd == OP_NACK);
        else if (k == 2) m_scl = 1'b1;
        else m_scl = 1'b0;
      end
      OP_WAIT: begin
        if (k == 0) m_scl = 1'b0;
        else if (k == 1) m_sda = 1'b1;
        else m_scl = 1'b1;
      end
      OP_SEND: begin
        if (k % 3 == 0) begin
          m_scl = 1'b0;
        end else if (k % 3 == 1) begin
          m_sda = m_shift[7];
          m_shift = {m_shift[6:0], 1'b0};
        end else begin
          m_scl = 1'b1;
        end
      end
      OP_RECV: begin
        if (k % 2 == 0) begin
          if (k == 0) m_sda = 1'b1;
          m_scl = 1'b0;
        end else begin
          m_scl = 1'b1;
        end
      end
      default: ;
    endcase
  endfunction

  // Close phase k, taking its sample; return 1 when a start finds the bus busy
  function automatic bit close_phase(input int k, input logic sda, input bit last);
    case (m_cmd)
      OP_START: begin
        if (k == 0 && !sda) begin
          m_flags[1] = 1'b0;
          return 1'b1;
        end
        if (k == 1 && sda) begin
          m_flags[1] = 1'b0;
          return 1'b1;
        end
        if (k == 2) m_flags[1] = 1'b1;
      end
      OP_WAIT: begin
        if (last) begin
          m_flags[0] = !sda;
          m_scl = 1'b0;
        end
      end
      OP_SEND: begin
        if (last) m_scl = 1'b0;
      end
      OP_RECV: begin
        if (k % 2 == 1) m_shift = {m_shift[6:0], sda};
        if (last) begin
          m_scl = 1'b0;
          m_rx = m_shift;
        end
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  // Advance the line model by one tick and return the result it forecasts
  function automatic res_item_t sequence_tick(input cmd_item_t it);
    res_item_t r;
    int        k;
    int        eff;
    int        base;
    bit        last;
    bit        abort;
    bit        done;
    done = 1'b0;
    if (m_step == 5'd0) begin
      if (it.cmd_valid && it.opcode != OP_NONE) begin
        m_cmd = it.opcode;
        m_count = 8'd0;
        m_shift = (it.opcode == OP_SEND) ? it.tx_byte : 8'h00;
        m_step = 5'd1;
        drive_phase(0);
      end
    end else begin
      eff = (m_phase_ticks == 8'd0) ? 1 : int'(m_phase_ticks);
      m_count = m_count + 8'd1;
      if (int'(m_count) >= eff) begin
        k = int'(m_step) - 1;
        base = int'(m_cmd) * 5;
        last = (k + 1) >= int'(PHASE_LEN[base +: 5]);
        abort = close_phase(k, it.sda_in, last);
        m_count = 8'd0;
        if (abort || last) begin
          m_step = 5'd0;
          done = 1'b1;
        end else begin
          m_step = 5'(k + 2);
          drive_phase(k + 1);
        end
      end
    end
    r.scl_out = m_scl;
    r.sda_out = m_sda;
    r.ready_res = (m_step == 5'd0);
    r.done_res = done;
    r.rx_byte = m_rx;
    r.ack_ok = m_flags[0];
    r.start_ok = m_flags[1];
    return r;
  endfunction

  function automatic void plan_row(input int cfg_before, input bit valid,
                                   input logic [2:0] op, input logic [7:0] tx,
                                   input sda_mode_e mode, input bit noise,
                                   input int mid_tick, input int mid_cfg,
                                   input bit typed, input res_item_t want);
    step_row_t r;
    r.cfg_before = cfg_before;
    r.valid = valid;
    r.op = op;
    r.tx = tx;
    r.mode = mode;
    r.noise = noise;
    r.mid_tick = mid_tick;
    r.mid_cfg = mid_cfg;
    r.typed = typed;
    r.want = want;
    plan.push_back(r);
  endfunction

  function automatic logic row_sda(input sda_mode_e mode);
    case (mode)
      SDA_LOW:  return 1'b0;
      SDA_HIGH: return 1'b1;
      SDA_RAND: return 1'($urandom_range(0, 1));
      default:  return m_sda;
    endcase
  endfunction

  // Mostly follow the driven level, as a quiet bus would; sample freely where
  // a slave drives the line
  function automatic logic random_sda();
    if (m_step != 5'd0 && (m_cmd == OP_WAIT || m_cmd == OP_RECV))
      return 1'($urandom_range(0, 1));
    if ($urandom_range(0, 99) < 85)
      return m_sda;
    return 1'($urandom_range(0, 1));
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    fail_count++;
    if (fail_count <= MAX_PRINTED)
      $display("mismatch on result %0d: %s got %h expected %h", res_count, what, got, want);
  endtask

  // Offer one tick, hold it until transferred, then log its forecast
  task automatic send_tick(input cmd_item_t it, input bit typed, input res_item_t want);
    res_item_t guess;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.data <= it;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    guess = sequence_tick(it);
    if (typed && m_step == 5'd0)
      bus_state_q.push_back(want);
    else
      bus_state_q.push_back(guess);
  endtask

  // Drop valid and wait for every forecast result to arrive
  task automatic hold_until_drained();
    cmd_ch.valid <= 1'b0;
    @(posedge clk);
    while (bus_state_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_phase_ticks(input logic [7:0] value);
    hold_until_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    m_phase_ticks = value;
  endtask

  // Receiver side: stall at random
  initial begin : res_stall
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      res_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Compare each result transfer with the oldest forecast
  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) begin
      res_count++;
      if (bus_state_q.size() == 0) begin
        report_mismatch("result with no tick pending", 8'h00, 8'h00);
      end else begin
        want_res = bus_state_q.pop_front();
        if (res_ch.data.scl_out !== want_res.scl_out)
          report_mismatch("scl_out", 8'(res_ch.data.scl_out), 8'(want_res.scl_out));
        if (res_ch.data.sda_out !== want_res.sda_out)
          report_mismatch("sda_out", 8'(res_ch.data.sda_out), 8'(want_res.sda_out));
        if (res_ch.data.ready_res !== want_res.ready_res)
          report_mismatch("ready_res", 8'(res_ch.data.ready_res), 8'(want_res.ready_res));
        if (res_ch.data.done_res !== want_res.done_res)
          report_mismatch("done_res", 8'(res_ch.data.done_res), 8'(want_res.done_res));
        if (res_ch.data.rx_byte !== want_res.rx_byte)
          report_mismatch("rx_byte", res_ch.data.rx_byte, want_res.rx_byte);
        if (res_ch.data.ack_ok !== want_res.ack_ok)
          report_mismatch("ack_ok", 8'(res_ch.data.ack_ok), 8'(want_res.ack_ok));
        if (res_ch.data.start_ok !== want_res.start_ok)
          report_mismatch("start_ok", 8'(res_ch.data.start_ok), 8'(want_res.start_ok));
      end
    end
  end

  // Stimulus
  initial begin : stimulus
    cmd_item_t it;
    step_row_t r;
    res_item_t none;
    int        n;
    int        ph;

    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_wdata <= 8'h00;
    cmd_ch.valid <= 1'b0;
    cmd_ch.data <= '0;

    m_phase_ticks = PHASE_TICKS_RESET;
    m_step = 5'd0;
    m_count = 8'd0;
    m_shift = 8'h00;
    m_cmd = OP_START;
    m_scl = 1'b1;
    m_sda = 1'b1;
    m_flags = 2'b00;
    m_rx = 8'h00;
    none = '0;

    // Directed table; typed results are taken on the row's last tick
    plan_row(NO_CFG, 1'b0, OP_START, 8'h00, SDA_HIGH, 1'b0, 0, 0, 1'b1,
             res_item_t'{1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0});
    plan_row(NO_CFG, 1'b1, OP_NONE, 8'hFF, SDA_LOW, 1'b0, 0, 0, 1'b1,
             res_item_t'{1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0});
    plan_row(NO_CFG, 1'b1, OP_START, 8'h00, SDA_FOLLOW, 1'b0, 0, 0, 1'b1,
             res_item_t'{1'b1, 1'b0, 1'b1, 1'b1, 8'h00, 1'b0, 1'b1});
    plan_row(1, 1'b1, OP_START, 8'h00, SDA_HIGH, 1'b0, 0, 0, 1'b1,
             res_item_t'{1'b1, 1'b0, 1'b1, 1'b1, 8'h00, 1'b0, 1'b0});
    plan_row(NO_CFG, 1'b1, OP_START, 8'h00, SDA_LOW, 1'b0, 0, 0, 1'b1,
             res_item_t'{1'b1, 1'b1, 1'b1, 1'b1, 8'h00, 1'b0, 1'b0});
    plan_row(NO_CFG, 1'b1, OP_START, 8'h00, SDA_FOLLOW, 1'b0, 0, 0, 1'b0, none);
    plan_row(NO_CFG, 1'b1, OP_SEND, 8'hFF, SDA_FOLLOW, 1'b0, 0, 0, 1'b0, none);
    plan_row(NO_CFG, 1'b1, OP_SEND, 8'h00, SDA_FOLLOW, 1'b1, 0, 0, 1'b0, none);
    plan_row(NO_CFG, 1'b1, OP_SEND, 8'hA5, SDA_RAND, 1'b0, 0, 0, 1'b0, none);
    plan_row(NO_CFG, 1'b1, OP_WAIT, 8'h00, SDA_LOW, 1'b0, 0, 0, 1'b1,
             res_item_t'{1'b0, 1'b1, 1'b1, 1'b1, 8'h00, 1'b1, 1'b1});
    plan_row(NO_CFG, 1'b1, OP_WAIT, 8'h00, SDA_HIGH, 1'b0, 0, 0, 1'b1,
             res_item_t'{1'b0, 1'b1, 1'b1, 1'b1, 8'h00, 1'b0, 1'b1});
    plan_row(NO_CFG, 1'b1, OP_RECV, 8'h00, SDA_HIGH, 1'b0, 0, 0, 1'b1,
             res_item_t'{1'b0, 1'b1, 1'b1, 1'b1, 8'hFF, 1'b0, 1'b1});
    plan_row(NO_CFG, 1'b1, OP_RECV, 8'h00, SDA_LOW, 1'b0, 0, 0, 1'b1,
             res_item_t'{1'b0, 1'b1, 1'b1, 1'b1, 8'h00, 1'b0, 1'b1});
    plan_row(NO_CFG, 1'b1, OP_RECV, 8'h5A, SDA_RAND, 1'b1, 0, 0, 1'b0, none);
    plan_row(NO_CFG, 1'b1, OP_ACK, 8'h00, SDA_FOLLOW, 1'b1, 0, 0, 1'b0, none);
    plan_row(NO_CFG, 1'b1, OP_NACK, 8'h00, SDA_FOLLOW, 1'b0, 0, 0, 1'b0, none);
    plan_row(0, 1'b1, OP_STOP, 8'h00, SDA_FOLLOW, 1'b0, 0, 0, 1'b0, none);
    // Longest phase, with a start that finds the bus busy after its first phase
    plan_row(255, 1'b1, OP_START, 8'h00, SDA_LOW, 1'b0, 0, 0, 1'b0, none);
    // Shorten the phase while the engine is part way through one
    plan_row(6, 1'b1, OP_SEND, 8'h3C, SDA_FOLLOW, 1'b0, 8, 2, 1'b0, none);
    plan_row(1, 1'b1, OP_WAIT, 8'h00, SDA_RAND, 1'b1, 0, 0, 1'b0, none);
    plan_row(NO_CFG, 1'b1, OP_START, 8'h00, SDA_RAND, 1'b0, 0, 0, 1'b0, none);
    plan_row(NO_CFG, 1'b1, OP_STOP, 8'h00, SDA_FOLLOW, 1'b0, 0, 0, 1'b0, none);

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Walk the table, running each command until the engine is idle again
    foreach (plan[i]) begin
      r = plan[i];
      if (r.cfg_before != NO_CFG) set_phase_ticks(8'(r.cfg_before));
      it.cmd_valid = r.valid;
      it.opcode = r.op;
      it.tx_byte = r.tx;
      it.sda_in = row_sda(r.mode);
      send_tick(it, r.typed, r.want);
      n = 0;
      while (m_step != 5'd0) begin
        n++;
        if (r.mid_tick != 0 && n == r.mid_tick) set_phase_ticks(8'(r.mid_cfg));
        it.cmd_valid = r.noise;
        it.opcode = 3'($urandom_range(0, 7));
        it.tx_byte = 8'($urandom);
        it.sda_in = row_sda(r.mode);
        send_tick(it, r.typed, r.want);
      end
    end

    // Random phases: receiver stalls most, then sender, then neither
    for (ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 27 : (ph == 1) ? 62 : 0;
      recv_idle_pct = (ph == 0) ? 62 : (ph == 1) ? 27 : 0;
      set_phase_ticks((ph == 0) ? 8'd1 : (ph == 1) ? 8'd2 : 8'($urandom_range(0, 3)));
      repeat (70) begin
        if (m_step == 5'd0)
          it.cmd_valid = ($urandom_range(0, 99) < 85);
        else
          it.cmd_valid = ($urandom_range(0, 99) < 10);
        it.opcode = 3'($urandom_range(0, 7));
        it.tx_byte = 8'($urandom);
        it.sda_in = random_sda();
        send_tick(it, 1'b0, none);
      end
      // Let the last command finish so the next setting lands on an idle engine
      while (m_step != 5'd0) begin
        it.cmd_valid = 1'b0;
        it.opcode = 3'($urandom_range(0, 7));
        it.tx_byte = 8'($urandom);
        it.sda_in = random_sda();
        send_tick(it, 1'b0, none);
      end
    end

    hold_until_drained();
    repeat (4) @(posedge clk);
    if (fail_count == 0 && bus_state_q.size() == 0) begin
      $display("PASS i2c_master_bit_engine_unit");
    end else begin
      $display("FAIL i2c_master_bit_engine_unit");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #2000000;
    $display("FAIL i2c_master_bit_engine_unit");
    $finish;
  end

endmodule

`default_nettype wire
